>>> rtl/tep_pkg.sv
// ----------------------------------------------------------------------------
// tep_pkg
// Types and constants shared by the exponential series evaluator.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int unsigned X_W      = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned X_FRAC   = 12;
    localparam int unsigned RCP_FRAC = 24;
    localparam int unsigned RCP_W    = RCP_FRAC + 1;
    localparam int unsigned MAG1_W   = 35;
    localparam int unsigned LO_W     = 18;
    localparam int unsigned HI_W     = MAG1_W - LO_W;

    localparam logic [CNT_W-1:0]         TERM_COUNT_RST = CNT_W'(16);
    localparam logic signed [SUM_W-1:0]  ONE_Q16        = 32'sd65536;
    localparam logic signed [SUM_W-1:0]  SAT_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0]  SAT_MIN        = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MULLO,
        S_MULHI,
        S_TERM,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mullo;
        logic mulhi;
        logic term;
        logic sum;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> rtl/tep_ctrl.sv
// ----------------------------------------------------------------------------
// tep_ctrl
// Sequencer: term counter, term count register and step control.
// ----------------------------------------------------------------------------
module tep_ctrl #(
    parameter int unsigned MAX_TERMS = 31,
    parameter int unsigned IDX_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [tep_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tep_pkg::t_status           i_status,
    output tep_pkg::t_cmd              o_cmd,
    output logic [IDX_W-1:0]           o_idx
);
    import tep_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_term_count;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_lim, n_lim;
    logic [IDX_W-1:0]      w_lim_cfg;

    assign w_lim_cfg = (32'(r_term_count) > MAX_TERMS) ? IDX_W'(MAX_TERMS)
                                                      : IDX_W'(r_term_count);
    assign o_idx     = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_COUNT_RST;
            r_idx        <= '0;
            r_lim        <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_lim   <= n_lim;
            if (i_cfg_wen) begin
                r_term_count <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_lim      = r_lim;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = IDX_W'(1);
                    n_lim      = w_lim_cfg;
                    n_state    = (w_lim_cfg == '0) ? S_DONE : S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MULLO;
            end
            S_MULLO: begin
                o_cmd.mullo = 1'b1;
                n_state     = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mulhi = 1'b1;
                n_state     = S_TERM;
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_idx == r_lim) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_MUL1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tep_datapath.sv
// ----------------------------------------------------------------------------
// tep_datapath
// Term and sum registers, shared multipliers, reciprocal table, result register.
// ----------------------------------------------------------------------------
module tep_datapath #(
    parameter int unsigned MAX_TERMS = 31,
    parameter int unsigned IDX_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tep_pkg::t_cmd                i_cmd,
    input  logic [IDX_W-1:0]             i_idx,
    output tep_pkg::t_status             o_status,
    input  logic [tep_pkg::X_W-1:0]      i_x,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tep_pkg::SUM_W-1:0]    o_out_sum,
    output logic                         o_out_ovf
);
    import tep_pkg::*;

    localparam int unsigned DEPTH = MAX_TERMS + 1;

    logic [RCP_W-1:0]            w_rcp_tab [DEPTH];
    logic [RCP_W-1:0]            w_rcp;

    logic [X_W-1:0]              r_x_mag;
    logic                        r_x_neg;
    logic signed [SUM_W-1:0]     r_term;
    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_ovf;
    logic                        r_neg;
    logic [MAG1_W-1:0]           r_mag1;
    logic [LO_W+RCP_W-1:0]       r_lo;
    logic [HI_W+RCP_W-1:0]       r_hi;
    logic                        r_out_valid;
    logic [SUM_W-1:0]            r_out_sum;
    logic                        r_out_ovf;

    logic [SUM_W-1:0]            w_term_mag;
    logic [SUM_W+X_W-1:0]        w_p;
    logic [59:0]                 w_full;
    logic [MAG1_W:0]             w_t2_mag;
    logic signed [MAG1_W+1:0]    w_t2;
    logic signed [SUM_W:0]       w_sum;

    assign w_rcp_tab[0] = RCP_W'(1 << RCP_FRAC);
    for (genvar g = 1; g < DEPTH; g++) begin : g_rcp
        localparam logic [RCP_W-1:0] RCP = RCP_W'(((1 << RCP_FRAC) + g / 2) / g);
        assign w_rcp_tab[g] = RCP;
    end
    assign w_rcp = w_rcp_tab[i_idx];

    assign w_term_mag = r_term[SUM_W-1] ? SUM_W'(-r_term) : SUM_W'(r_term);
    assign w_p        = (SUM_W+X_W)'(w_term_mag) * (SUM_W+X_W)'(r_x_mag);
    assign w_full     = (60'(r_hi) << LO_W) + 60'(r_lo) + 60'(1 << (RCP_FRAC - 1));
    assign w_t2_mag   = w_full[RCP_FRAC+MAG1_W:RCP_FRAC];
    assign w_t2       = r_neg ? -$signed({1'b0, w_t2_mag}) : $signed({1'b0, w_t2_mag});
    assign w_sum      = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_term);

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_sum         = r_out_sum;
    assign o_out_ovf         = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_neg <= i_x[X_W-1];
            r_x_mag <= i_x[X_W-1] ? X_W'(-i_x) : i_x;
            r_term  <= ONE_Q16;
            r_sum   <= ONE_Q16;
            r_ovf   <= 1'b0;
        end
        if (i_cmd.mul1) begin
            r_mag1 <= MAG1_W'((w_p + (SUM_W+X_W)'(1 << (X_FRAC - 1))) >> X_FRAC);
            r_neg  <= r_term[SUM_W-1] ^ r_x_neg;
        end
        if (i_cmd.mullo) begin
            r_lo <= (LO_W+RCP_W)'(r_mag1[LO_W-1:0]) * (LO_W+RCP_W)'(w_rcp);
        end
        if (i_cmd.mulhi) begin
            r_hi <= (HI_W+RCP_W)'(r_mag1[MAG1_W-1:LO_W]) * (HI_W+RCP_W)'(w_rcp);
        end
        if (i_cmd.term) begin
            if (w_t2 > (MAG1_W+2)'(SAT_MAX)) begin
                r_term <= SAT_MAX;
                r_ovf  <= 1'b1;
            end else if (w_t2 < (MAG1_W+2)'(SAT_MIN)) begin
                r_term <= SAT_MIN;
                r_ovf  <= 1'b1;
            end else begin
                r_term <= SUM_W'(w_t2);
            end
        end
        if (i_cmd.sum) begin
            if (w_sum > (SUM_W+1)'(SAT_MAX)) begin
                r_sum <= SAT_MAX;
                r_ovf <= 1'b1;
            end else if (w_sum < (SUM_W+1)'(SAT_MIN)) begin
                r_sum <= SAT_MIN;
                r_ovf <= 1'b1;
            end else begin
                r_sum <= SUM_W'(w_sum);
            end
        end
        if (i_cmd.out_load) begin
            r_out_sum <= r_sum;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/taylor_exp_evaluator_unit.sv
// ----------------------------------------------------------------------------
// taylor_exp_evaluator_unit
// Truncated Taylor series for exp(x): Q3.12 argument in, saturated Q15.16 out.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lsb up)                 Request
// s_axis    in   tdata: x_value[15:0]             one argument
// m_axis    out  tdata: exp_value[31:0]           one series sum
//                tuser: overflow[0]
// cfg       in   i_cfg_wdata: term_count[4:0]     register write, no wait
//
// An argument runs N terms, N the term count capped at MAX_TERMS:
// each term passes through a multiply by x, two partial-product multiplies, a
// round and saturate step, and a sum step, all on one shared datapath.
// Reset clears the sequencer and result valid; term count returns to 16.
// A new argument is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
module taylor_exp_evaluator_unit #(
    parameter int unsigned MAX_TERMS = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [tep_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // x_value[15:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // exp_value[31:0]
    output logic [0:0]                  m_axis_tuser    // overflow
);
    import tep_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_TERMS + 1);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [IDX_W-1:0]   w_idx;
    logic               w_ovf;

    tep_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    tep_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_status    (w_status),
        .i_x         (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_sum   (m_axis_tdata),
        .o_out_ovf   (w_ovf)
    );

    assign m_axis_tuser = w_ovf;

endmodule
